/* design/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, constants and palette functions for the nearest palette
// color core.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int unsigned BasicEntries = 16;
	localparam int unsigned CubeEntries  = 216;
	localparam int unsigned GreyEntries  = 24;
	localparam int unsigned CubeDigits   = 6;
	localparam int unsigned GreyBase     = 8;
	localparam int unsigned GreyStep     = 10;
	localparam int unsigned XtermOffset  = 16;

	localparam logic [7:0] LastBasic = 8'(BasicEntries - 1);
	localparam logic [7:0] LastXterm = 8'(CubeEntries + GreyEntries - 1);
	localparam logic [7:0] XtermBase = 8'(XtermOffset);
	localparam logic [2:0] LastDigit = 3'(CubeDigits - 1);

	localparam int unsigned DistW = 18;   // 3 * 255^2 < 2^18

	localparam logic       ModeBasic = 1'b0;
	localparam logic       ModeXterm = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // capture request, reset search
		logic issue;   // push current entry into the distance pipe
		logic emit;    // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_last; // entry counter points at the last palette entry
		logic done;    // best index holds the final answer
	} dp_stat_t;

	function automatic logic [23:0] basic_rgb(input logic [3:0] n);
		logic [23:0] c;
		case (n)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'h800000;
			4'd2:    c = 24'h008000;
			4'd3:    c = 24'h808000;
			4'd4:    c = 24'h000080;
			4'd5:    c = 24'h800080;
			4'd6:    c = 24'h008080;
			4'd7:    c = 24'hc0c0c0;
			4'd8:    c = 24'h808080;
			4'd9:    c = 24'hFF0000;
			4'd10:   c = 24'h00FF00;
			4'd11:   c = 24'hFFFF00;
			4'd12:   c = 24'h0000FF;
			4'd13:   c = 24'hFF00FF;
			4'd14:   c = 24'h00FFFF;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] cube_level(input logic [2:0] d);
		logic [7:0] v;
		case (d)
			3'd0:    v = 8'h00;
			3'd1:    v = 8'h5f;
			3'd2:    v = 8'h87;
			3'd3:    v = 8'haf;
			3'd4:    v = 8'hd7;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] grey_level(input logic [4:0] k);
		logic [8:0] v;
		v = 9'(GreyBase) + 9'(GreyStep) * {4'd0, k};
		return v[7:0];
	endfunction

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* design/npc_ctrl.sv */
// ----------------------------------------------------------------------------
// npc_ctrl
// Search sequencer: accepts a request, walks the palette, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module npc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_free,
	input  npc_pkg::dp_stat_t stat,
	output npc_pkg::dp_cmd_t  cmd
);
	import npc_pkg::*;

	ctl_state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (stat.at_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.done && out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/npc_datapath.sv */
// ----------------------------------------------------------------------------
// npc_datapath
// Palette entry walker, two-stage distance pipe and running minimum.
// ----------------------------------------------------------------------------
module npc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  npc_pkg::dp_cmd_t  cmd,
	input  logic              mode,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output npc_pkg::dp_stat_t stat,
	output logic              mode_used,
	output logic [7:0]        result
);
	import npc_pkg::*;

	logic [7:0]       r_q, g_q, b_q;
	logic             mode_q;
	logic [7:0]       n_q;
	logic [2:0]       cr_q, cg_q, cb_q;
	logic [7:0]       last_n;
	logic [7:0]       grey_k;
	logic [23:0]      entry;

	// stage 1: channel differences
	logic             v_s1, last_s1;
	logic [7:0]       idx_s1;
	logic [7:0]       dr_s1, dg_s1, db_s1;

	// stage 2: distance
	logic             v_s2, last_s2;
	logic [7:0]       idx_s2;
	logic [DistW-1:0] dist_s2;
	logic [15:0]      sq_r, sq_g, sq_b;

	// running best
	logic [DistW-1:0] best_d_q;
	logic [7:0]       best_i_q;
	logic             done_q;

	assign last_n = (mode_q == ModeXterm) ? LastXterm : LastBasic;
	assign grey_k = n_q - 8'(CubeEntries);

	always_comb begin
		if (mode_q == ModeBasic) begin
			entry = basic_rgb(n_q[3:0]);
		end else if (n_q < 8'(CubeEntries)) begin
			entry = {cube_level(cr_q), cube_level(cg_q), cube_level(cb_q)};
		end else begin
			entry = {3{grey_level(grey_k[4:0])}};
		end
	end

	assign stat.at_last = (n_q == last_n);
	assign stat.done    = done_q;
	assign mode_used    = mode_q;
	assign result       = (mode_q == ModeXterm) ? (best_i_q + XtermBase) : best_i_q;

	// request capture and entry walk (cube digits count in base six)
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q    <= red;
			g_q    <= green;
			b_q    <= blue;
			mode_q <= mode;
			n_q    <= '0;
			cr_q   <= '0;
			cg_q   <= '0;
			cb_q   <= '0;
		end else if (cmd.issue) begin
			n_q <= n_q + 8'd1;
			if (cb_q == LastDigit) begin
				cb_q <= '0;
				if (cg_q == LastDigit) begin
					cg_q <= '0;
					cr_q <= (cr_q == LastDigit) ? 3'd0 : cr_q + 3'd1;
				end else begin
					cg_q <= cg_q + 3'd1;
				end
			end else begin
				cb_q <= cb_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= n_q;
		last_s1 <= stat.at_last;
		dr_s1   <= abs_diff(r_q, entry[23:16]);
		dg_s1   <= abs_diff(g_q, entry[15:8]);
		db_s1   <= abs_diff(b_q, entry[7:0]);
	end

	assign sq_r = dr_s1 * dr_s1;
	assign sq_g = dg_s1 * dg_s1;
	assign sq_b = db_s1 * db_s1;

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		dist_s2 <= DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);
	end

	// later entry wins a tie
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_d_q <= '1;
			best_i_q <= '0;
		end else if (v_s2 && (dist_s2 <= best_d_q)) begin
			best_d_q <= dist_s2;
			best_i_q <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.start) begin
				done_q <= 1'b0;
			end else if (v_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule

/* design/nearest_palette_color_core.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Maps a 24-bit RGB color to the index of the nearest terminal palette entry.
// ----------------------------------------------------------------------------
// One request carries red, green and blue; one result carries palette_index,
// the entry with the smallest sum of squared channel differences (on a tie the
// higher entry number wins). palette_mode selects the palette: 0 searches the
// 16 basic ANSI colors and returns 0..15, 1 (reset value) searches the 216
// cube and 24 grey entries and returns 16..255. Write palette_mode only while
// no request is in flight. A single distance unit walks the palette one entry
// per cycle through a two-stage difference/square pipe, over the 16 basic
// entries or the 240 xterm entries. in_stall is high for the whole search;
// the result sits in an output register, so the next request is taken as
// soon as the previous result is loaded there, even if the sink is still
// stalling.
// ----------------------------------------------------------------------------
module nearest_palette_color_core (
	input  logic       clk,
	input  logic       arst_n,
	// config
	input  logic       palette_mode_wr_en,
	input  logic       palette_mode,
	// request
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	// result
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] palette_index
);
	import npc_pkg::*;

	logic       mode_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic       out_free;
	logic       mode_used;
	logic [7:0] result;
	logic       out_valid_q;
	logic [7:0] palette_index_q;

	// mode register, reset to the xterm palette
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeXterm;
		end else if (palette_mode_wr_en) begin
			mode_q <= palette_mode;
		end
	end

	// result register may be refilled in the cycle the sink takes it
	assign out_free = !out_valid_q || !out_stall;

	npc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	npc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode_q),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.stat      (stat),
		.mode_used (mode_used),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			palette_index_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign palette_index = palette_index_q;

	// an accepted request keeps the input side closed for the search
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	// a result is only loaded once the search finished and the register is free
	a_emit_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (stat.done && out_free))
		else $error("result loaded early");

	// the index range follows the palette used for the search
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> ((mode_used == ModeXterm) ? (palette_index >= XtermBase)
			: (palette_index <= LastBasic)))
		else $error("palette index out of range for mode");

	// no result while a search is starting
	a_no_emit_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !cmd.emit && !cmd.issue)
		else $error("start overlaps search");

endmodule

/* tb/sv/tb_nearest_palette_color_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_core
// Self-checking bench for the nearest palette color core: every accepted RGB
// request is scored against an in-bench nearest-entry search over both
// palettes, under random source gaps, sink stalls and long back-pressure.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_core;
	import npc_pkg::*;

	localparam int ResetCycles    = 7;
	localparam int SinkHoldCycles = 300;   // long sink hold-off, fills the core
	localparam int DrainCycles    = 300;   // > worst search, waited out after the last result
	localparam int IdleLimit      = 4000;  // cycles with no request and no result moving
	localparam int ReportLimit    = 10;

	// basic ANSI palette, entry n at bits [24*n +: 24]
	localparam logic [16*24-1:0] AnsiPalette = {
		24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h0000FF,
		24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h808080,
		24'hc0c0c0, 24'h008080, 24'h800080, 24'h000080,
		24'h808000, 24'h008000, 24'h800000, 24'h000000
	};
	// xterm cube channel levels, digit d at bits [8*d +: 8]
	localparam logic [6*8-1:0] CubeLevels = {8'hff, 8'hd7, 8'haf, 8'h87, 8'h5f, 8'h00};
	// channel values halfway between two palette levels (tie bait)
	localparam logic [8*8-1:0] TieLevels = {
		8'd64, 8'd115, 8'd155, 8'd160, 8'd195, 8'd235, 8'd13, 8'd103
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct {
		rgb_t       color;
		logic       mode;
		logic [7:0] index;
	} color_result_t;

	// ------------------------------------------------------------------
	// DUT signals: every input has a known value from time zero
	// ------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       palette_mode_wr_en = 1'b0;
	logic       palette_mode = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] palette_index;

	nearest_palette_color_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.palette_mode_wr_en (palette_mode_wr_en),
		.palette_mode       (palette_mode),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.palette_index      (palette_index)
	);

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	color_result_t pending_index_q[$];   // one entry per accepted request, oldest first
	logic       active_mode = ModeXterm; // shadow of the mode register, reset value
	logic       req_up = 1'b0;           // in_valid currently driven high
	bit         src_idle_on = 1'b1;
	bit         sink_idle_on = 1'b1;
	int         sink_hold_request = 0;   // posted at negedge, picked up by the sink
	int         hold_left = 0;
	int         sink_wait = 0;
	logic       result_shown = 1'b0;
	logic       result_taken;
	logic [7:0] shown_index = 8'd0;
	int         requests_sent = 0;
	int         results_checked = 0;
	int         fail_count = 0;
	int         mode_writes = 0;
	int         sent_basic = 0;
	int         sent_xterm = 0;
	int         longest_hold = 0;
	int         seen_sent = 0;
	int         seen_checked = 0;
	int         idle_cycles = 0;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// nearest-entry search
	// ------------------------------------------------------------------
	function automatic int unsigned color_distance(input rgb_t a, input rgb_t p);
		int dr, dg, db;
		dr = int'(a.red) - int'(p.red);
		dg = int'(a.green) - int'(p.green);
		db = int'(a.blue) - int'(p.blue);
		return dr * dr + dg * dg + db * db;
	endfunction

	// full walk of the selected palette; "<=" lets the later entry win a tie
	function automatic logic [7:0] nearest_index(input logic mode, input rgb_t c);
		rgb_t        entry;
		logic [7:0]  level;
		int unsigned best_dist;
		int unsigned d;
		int          best;
		int          n;
		best_dist = 32'hFFFF_FFFF;
		best = 0;
		if (mode == ModeBasic) begin
			for (n = 0; n < BasicEntries; n++) begin
				entry = AnsiPalette[n * 24 +: 24];
				d = color_distance(c, entry);
				if (d <= best_dist) begin
					best_dist = d;
					best = n;
				end
			end
		end else begin
			for (n = 0; n < CubeEntries + GreyEntries; n++) begin
				if (n < CubeEntries) begin
					// 6x6x6 cube, red is the most significant digit
					entry.red   = CubeLevels[(n / 36) * 8 +: 8];
					entry.green = CubeLevels[((n / 6) % 6) * 8 +: 8];
					entry.blue  = CubeLevels[(n % 6) * 8 +: 8];
				end else begin
					level = 8'(8 + 10 * (n - CubeEntries));
					entry = {level, level, level};
				end
				d = color_distance(c, entry);
				if (d <= best_dist) begin
					best_dist = d;
					best = n;
				end
			end
			best += XtermOffset;
		end
		return 8'(best);
	endfunction

	// ------------------------------------------------------------------
	// random colors, biased toward palette levels and tie points
	// ------------------------------------------------------------------
	function automatic logic [7:0] jitter(input logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(4, 0)) - 2;
		if (t < 0)
			t = 0;
		else if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	function automatic logic [7:0] random_channel();
		logic [7:0] v;
		int         k;
		case ($urandom_range(4, 0))
			0, 1: begin
				v = 8'($urandom_range(255, 0));
			end
			2: begin
				k = $urandom_range(5, 0);
				v = jitter(CubeLevels[k * 8 +: 8]);
			end
			3: begin
				k = $urandom_range(7, 0);
				v = TieLevels[k * 8 +: 8];
			end
			default: begin
				v = jitter($urandom_range(1, 0) ? 8'h80 : 8'hc0);
			end
		endcase
		return v;
	endfunction

	function automatic rgb_t random_color();
		rgb_t       c;
		logic [7:0] g;
		// a quarter of the colors are neutral, to hit the grey ramp
		if ($urandom_range(3, 0) == 0) begin
			if ($urandom_range(1, 0))
				g = random_channel();
			else
				g = jitter(8'(8 + 10 * $urandom_range(23, 0)));
			c = {g, g, g};
		end else begin
			c.red   = random_channel();
			c.green = random_channel();
			c.blue  = random_channel();
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic lower_request();
		if (req_up) begin
			in_valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	// Offer one request and return in the step it is accepted. in_valid is
	// left high so back-to-back requests never drop it for a cycle.
	task automatic send_color(input rgb_t c);
		int   gap;
		logic stalled;
		color_result_t want;
		gap = src_idle_on ? $urandom_range(3, 0) : 0;
		if (gap > 0) begin
			lower_request();
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= c.red;
		green    <= c.green;
		blue     <= c.blue;
		req_up = 1'b1;
		// in_stall is stable between negedge and the next rising edge
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		want.color = c;
		want.mode  = active_mode;
		want.index = nearest_index(active_mode, c);
		pending_index_q = {pending_index_q, want};
		requests_sent++;
		if (active_mode == ModeBasic)
			sent_basic++;
		else
			sent_xterm++;
	endtask

	task automatic wait_all_results();
		lower_request();
		while (pending_index_q.size() != 0)
			@(posedge clk);
	endtask

	// mode is written only with nothing in flight; the data pin is flipped
	// afterwards to show it is ignored while the enable is low
	task automatic set_palette_mode(input logic m);
		wait_all_results();
		palette_mode_wr_en <= 1'b1;
		palette_mode       <= m;
		@(posedge clk);
		active_mode = m;
		mode_writes++;
		palette_mode_wr_en <= 1'b0;
		palette_mode       <= ~m;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= ReportLimit)
			$display("MISMATCH: %s", msg);
	endtask

	task automatic check_palette_index(input logic [7:0] got);
		color_result_t want;
		results_checked++;
		if (pending_index_q.size() == 0) begin
			note_failure($sformatf("palette_index %0d arrived with no request pending", got));
		end else begin
			want = pending_index_q.pop_front();
			if (got !== want.index)
				note_failure($sformatf("rgb %02h%02h%02h mode %0d: expected %0d, got %0d",
					want.color.red, want.color.green, want.color.blue, want.mode,
					want.index, got));
		end
	endtask

	// outputs sampled mid-cycle, so the rising edge sees settled values
	always @(negedge clk) begin
		result_shown = out_valid;
		shown_index  = palette_index;
	end

	// Sink: checks each accepted result, then, when sink idling is on, holds off
	// a shown result by a random wait before the next one. A posted hold-off
	// overrides that and keeps out_stall high for the whole stretch, counted here.
	always @(posedge clk) begin
		result_taken = arst_n && result_shown && !out_stall;
		if (result_taken)
			check_palette_index(shown_index);
		if (sink_hold_request > 0) begin
			hold_left = sink_hold_request;
			if (sink_hold_request > longest_hold)
				longest_hold = sink_hold_request;
			sink_hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (result_taken)
				sink_wait = sink_idle_on ? $urandom_range(3, 0) : 0;
			else if (result_shown && sink_wait > 0)
				sink_wait--;
			out_stall <= (sink_wait != 0);
		end
	end

	// watchdog: any accepted request or result counts as progress
	always @(negedge clk) begin
		if (requests_sent != seen_sent || results_checked != seen_checked) begin
			seen_sent    = requests_sent;
			seen_checked = results_checked;
			idle_cycles  = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("timeout: nothing moved for %0d cycles, %0d results outstanding",
				IdleLimit, pending_index_q.size());
			$display("tb_nearest_palette_color_core failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// register still at its reset value: xterm palette
	task automatic test_xterm_directed();
		send_color({8'h00, 8'h00, 8'h00});   // black cube corner
		send_color({8'hFF, 8'hFF, 8'hFF});   // white cube corner
		send_color({8'd115, 8'd115, 8'd115}); // halfway 5f/87 on all channels
		send_color({8'h08, 8'h08, 8'h08});   // darkest grey
		send_color({8'hee, 8'hee, 8'hee});   // lightest grey, top index
		send_color({8'h5f, 8'h87, 8'haf});   // exact cube entry
	endtask

	// every basic entry exactly, plus two equal-distance cases
	task automatic test_basic_directed();
		int n;
		set_palette_mode(ModeBasic);
		for (n = 0; n < BasicEntries; n++)
			send_color(AnsiPalette[n * 24 +: 24]);
		send_color({8'h40, 8'h00, 8'h00});   // 000000 vs 800000
		send_color({8'ha0, 8'ha0, 8'ha0});   // c0c0c0 vs 808080
	endtask

	task automatic test_random_colors(input logic mode, input int count);
		int i;
		set_palette_mode(mode);
		for (i = 0; i < count; i++) begin
			// every 50 requests re-roll the idling, mostly on
			if (i % 50 == 0) begin
				src_idle_on  = ($urandom_range(3, 0) != 0);
				sink_idle_on = ($urandom_range(3, 0) != 0);
			end
			send_color(random_color());
		end
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// sink holds off while the source keeps offering back to back, so the
	// output register fills and the core stalls its input
	task automatic test_sink_hold_off();
		set_palette_mode(ModeBasic);
		@(negedge clk);
		sink_hold_request = SinkHoldCycles;
		@(posedge clk);
		src_idle_on = 1'b0;
		repeat (12)
			send_color(random_color());
		src_idle_on = 1'b1;
	endtask

	// source goes quiet until the core has delivered everything
	task automatic test_source_pause();
		set_palette_mode(ModeXterm);
		repeat (3) begin
			repeat (10)
				send_color(random_color());
			wait_all_results();
		end
	endtask

	// no idling on either side
	task automatic test_steady_stream(input logic mode, input int count);
		set_palette_mode(mode);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		repeat (count)
			send_color(random_color());
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (ResetCycles) @(posedge clk);
		// release away from the rising edge to keep clear of recovery
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_xterm_directed();
		test_basic_directed();
		test_random_colors(ModeBasic, 300);
		test_sink_hold_off();
		test_random_colors(ModeXterm, 400);
		test_source_pause();
		test_steady_stream(ModeXterm, 150);   // same mode written again
		test_random_colors(ModeBasic, 250);
		test_steady_stream(ModeBasic, 100);
		test_random_colors(ModeXterm, 250);

		wait_all_results();
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d requests (%0d basic palette, %0d xterm palette), %0d mode writes",
			requests_sent, sent_basic, sent_xterm, mode_writes);
		$display("%0d results checked, longest sink hold-off %0d cycles, %0d mismatches",
			results_checked, longest_hold, fail_count);
		if (fail_count == 0)
			$display("tb_nearest_palette_color_core passed");
		else
			$display("tb_nearest_palette_color_core failed");
		$finish;
	end

endmodule
